// ===== rtl/core/prtd_pkg.sv =====
// shared types, constants and address folding for the palette ram tile row decoder
`timescale 1ns / 1ps
`default_nettype none

package prtd_pkg;

  localparam int TILE_WIDTH  = 8;
  localparam int ADDR_W      = 5;
  localparam int BYTE_W      = 8;
  localparam int PAL_W       = 3;
  localparam int COLOR_W     = 6;
  localparam int POS_W       = 3;
  localparam int RAM_DEPTH   = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_DECODE = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_value;
    logic [BYTE_W-1:0] plane_low;
    logic [BYTE_W-1:0] plane_high;
    logic [PAL_W-1:0]  palette_number;
  } cmd_t;

  // background entries of the sprite palettes fold onto the shared entries
  function automatic logic [ADDR_W-1:0] fold_address(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] m;
    m = a;
    if (a[4] && (a[1:0] == 2'b00)) begin
      m = {1'b0, a[3:0]};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/prtd_front.sv =====
// front end: accepts requests, drops unused codes and queues the rest
`timescale 1ns / 1ps
`default_nettype none

module prtd_front
  import prtd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire cmd_t  in_cmd,
  output logic       q_valid,
  input  wire logic  q_pop,
  output cmd_t       q_cmd
);

  cmd_t       entry_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  logic       keep;

  assign in_ready = (count_r != 2'(QUEUE_DEPTH));
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    case (in_cmd.action) inside
      ACT_WRITE, ACT_READ, ACT_DECODE: keep = 1'b1;
      default:                         keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep;
  assign pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prtd_back.sv =====
// back end: palette ram, tile row sequencer and output register
`timescale 1ns / 1ps
`default_nettype none

module prtd_back
  import prtd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire cmd_t        q_cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [BYTE_W-1:0]  out_read_byte,
  output logic [COLOR_W-1:0] out_color_index,
  output logic [POS_W-1:0]   out_pixel_position,
  output logic             out_last
);

  typedef enum logic {
    ST_IDLE,
    ST_DECODE
  } state_t;

  state_t             state_r;
  logic [BYTE_W-1:0]  ram_r [RAM_DEPTH];
  logic [BYTE_W-1:0]  lo_r;
  logic [BYTE_W-1:0]  hi_r;
  logic [PAL_W-1:0]   pal_r;
  logic [POS_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  read_byte_r;
  logic [COLOR_W-1:0] color_r;
  logic [POS_W-1:0]   pos_r;
  logic               last_r;

  logic               can_load;
  logic               out_load;
  logic               ram_we;
  logic [ADDR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0]  rd_data;
  logic [1:0]         pix;
  logic [PAL_W-1:0]   pix_pal;

  assign can_load = !out_valid_r || out_ready;

  // a new result enters the output register
  assign out_load = (state_r == ST_DECODE) ? can_load :
                    (q_valid && can_load &&
                     (q_cmd.action == ACT_READ || q_cmd.action == ACT_DECODE));

  // pixel value from the leftmost remaining plane bits
  always_comb begin
    if (state_r == ST_DECODE) begin
      pix     = {hi_r[BYTE_W-1], lo_r[BYTE_W-1]};
      pix_pal = pal_r;
    end else begin
      pix     = {q_cmd.plane_high[BYTE_W-1], q_cmd.plane_low[BYTE_W-1]};
      pix_pal = q_cmd.palette_number;
    end
  end

  always_comb begin
    q_pop  = 1'b0;
    ram_we = 1'b0;
    if (state_r == ST_IDLE && q_valid) begin
      unique case (q_cmd.action) inside
        ACT_WRITE: begin
          q_pop  = 1'b1;
          ram_we = 1'b1;
        end
        ACT_READ, ACT_DECODE: q_pop = can_load;
        default:              q_pop = 1'b1;
      endcase
    end
  end

  always_comb begin
    if (state_r == ST_IDLE && q_cmd.action == ACT_READ) begin
      rd_addr = fold_address(q_cmd.address);
    end else begin
      rd_addr = fold_address({pix_pal, pix});
    end
  end

  assign rd_data = ram_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RAM_DEPTH; i++) begin
        ram_r[i] <= '0;
      end
    end else if (ram_we) begin
      ram_r[fold_address(q_cmd.address)] <= q_cmd.write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid && can_load) begin
            if (q_cmd.action == ACT_READ) begin
              read_byte_r <= rd_data;
              color_r     <= '0;
              pos_r       <= '0;
              last_r      <= 1'b1;
            end else if (q_cmd.action == ACT_DECODE) begin
              read_byte_r <= '0;
              color_r     <= rd_data[COLOR_W-1:0];
              pos_r       <= '0;
              last_r      <= 1'b0;
              lo_r        <= q_cmd.plane_low << 1;
              hi_r        <= q_cmd.plane_high << 1;
              pal_r       <= q_cmd.palette_number;
              cnt_r       <= POS_W'(1);
              state_r     <= ST_DECODE;
            end
          end
        end
        ST_DECODE: begin
          if (can_load) begin
            read_byte_r <= '0;
            color_r     <= rd_data[COLOR_W-1:0];
            pos_r       <= cnt_r;
            last_r      <= (cnt_r == POS_W'(TILE_WIDTH - 1));
            lo_r        <= lo_r << 1;
            hi_r        <= hi_r << 1;
            cnt_r       <= cnt_r + POS_W'(1);
            if (cnt_r == POS_W'(TILE_WIDTH - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_byte      = read_byte_r;
  assign out_color_index    = color_r;
  assign out_pixel_position = pos_r;
  assign out_last           = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/palette_ram_tile_row_decoder.sv =====
// top level of the palette ram tile row decoder
`timescale 1ns / 1ps
`default_nettype none

// Palette RAM (32 x 8, zero after reset, background entries 0x10/0x14/0x18/0x1C
// mirrored onto 0x00/0x04/0x08/0x0C) with tile row decode. Requests enter a
// two-entry queue and are carried out in order by a sequencer behind it. A write
// updates the palette RAM in the sequencer and gives no result; a read gives one
// result, loaded into the output register at the edge where the sequencer takes
// it; a decode gives eight pixel results, one per cycle while the result side
// does not stall. That rate is set by the single read port of the palette RAM,
// which serves one pixel lookup per cycle. Backpressure on the result side stalls
// the sequencer only; the queue keeps taking requests until it is full.
module palette_ram_tile_row_decoder
  import prtd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // address, write_value, plane_low, plane_high, palette_number
  input  wire logic [1:0]  in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // read_byte, color_index, pixel_position, zero pad
  output logic             out_tlast
);

  cmd_t               in_cmd;
  cmd_t               q_cmd;
  logic               q_valid;
  logic               q_pop;
  logic [BYTE_W-1:0]  read_byte;
  logic [COLOR_W-1:0] color_index;
  logic [POS_W-1:0]   pixel_position;

  always_comb begin
    in_cmd.action         = in_tuser;
    in_cmd.address        = in_tdata[4:0];
    in_cmd.write_value    = in_tdata[12:5];
    in_cmd.plane_low      = in_tdata[20:13];
    in_cmd.plane_high     = in_tdata[28:21];
    in_cmd.palette_number = in_tdata[31:29];
  end

  prtd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  prtd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_cmd              (q_cmd),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_read_byte      (read_byte),
    .out_color_index    (color_index),
    .out_pixel_position (pixel_position),
    .out_last           (out_tlast)
  );

  assign out_tdata = {7'd0, pixel_position, color_index, read_byte};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the palette ram tile row decoder
`timescale 1ns / 1ps

module tb_top;
  import prtd_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [5:0] color_index;
    logic [2:0] pixel_pos;
    logic       last;
  } palette_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // address, write_value, plane_low, plane_high, palette_number
  logic [1:0]  in_tuser = '0;  // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // read_byte, color_index, pixel_position, zero pad
  logic        out_tlast;

  logic [7:0]      palette_shadow [RAM_DEPTH];
  palette_result_t awaited_results [$];
  palette_result_t seen_result;
  palette_result_t want_result;
  int              mismatch_count = 0;
  int              hold_left = 0;
  int              stall_pct = 0;
  int              rx_cycles = 0;
  int              burst_left = 0;
  bit              gaps_enabled = 1'b0;

  palette_ram_tile_row_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // sprite background entries share the universal background slots
  function automatic logic [4:0] mirror_entry(input logic [4:0] a);
    case (a)
      5'h10, 5'h14, 5'h18, 5'h1C: return {1'b0, a[3:0]};
      default: return a;
    endcase
  endfunction

  function automatic void predict_palette_request(input logic [1:0] action,
                                                  input logic [4:0] addr,
                                                  input logic [7:0] wval,
                                                  input logic [7:0] plo,
                                                  input logic [7:0] phi,
                                                  input logic [2:0] pal);
    palette_result_t r;
    logic [4:0]      entry;
    case (action)
      ACT_WRITE: begin
        palette_shadow[mirror_entry(addr)] = wval;
      end
      ACT_READ: begin
        r = '{read_byte: palette_shadow[mirror_entry(addr)], color_index: 6'd0,
              pixel_pos: 3'd0, last: 1'b1};
        awaited_results.push_back(r);
      end
      ACT_DECODE: begin
        for (int k = 0; k < TILE_WIDTH; k++) begin
          entry = {pal, phi[7-k], plo[7-k]};
          r = '{read_byte: 8'd0, color_index: palette_shadow[mirror_entry(entry)][5:0],
                pixel_pos: 3'(k), last: (k == TILE_WIDTH - 1)};
          awaited_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // receiver: random stall level that drifts, plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 48 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = '{read_byte: out_tdata[7:0], color_index: out_tdata[13:8],
                      pixel_pos: out_tdata[16:14], last: out_tlast};
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count < 40)
          $display("%0t unexpected result: byte %h color %h pos %0d last %b", $time,
                   seen_result.read_byte, seen_result.color_index,
                   seen_result.pixel_pos, seen_result.last);
      end else begin
        want_result = awaited_results.pop_front();
        if (seen_result !== want_result) begin
          mismatch_count++;
          if (mismatch_count < 40)
            $display("%0t mismatch: expected byte %h color %h pos %0d last %b, %s %h %h %0d %b",
                     $time, want_result.read_byte, want_result.color_index,
                     want_result.pixel_pos, want_result.last, "got",
                     seen_result.read_byte, seen_result.color_index,
                     seen_result.pixel_pos, seen_result.last);
        end
      end
    end
  end

  task automatic send_request(input logic [1:0] action, input logic [4:0] addr,
                              input logic [7:0] wval, input logic [7:0] plo,
                              input logic [7:0] phi, input logic [2:0] pal);
    int gap;
    if (gaps_enabled && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {pal, phi, plo, wval, addr};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    predict_palette_request(action, addr, wval, plo, phi, pal);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // a trailing write may still be in the sequencer
    repeat (16) @(posedge clk);
  endtask

  task automatic send_random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      send_request(ACT_WRITE, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   3'($urandom));
    else if (pick < 50)
      send_request(ACT_READ, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   3'($urandom));
    else if (pick < 95)
      send_request(ACT_DECODE, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   3'($urandom));
    else
      send_request(ACT_IGNORED, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   3'($urandom));
  endtask

  task automatic test_reset_state();
    send_request(ACT_READ, 5'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    send_request(ACT_READ, 5'h1F, 8'hFF, 8'hFF, 8'hFF, 3'd7);
  endtask

  task automatic test_mirroring();
    send_request(ACT_WRITE, 5'h10, 8'hFF, 8'h00, 8'h00, 3'd0);
    send_request(ACT_READ,  5'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    send_request(ACT_READ,  5'h10, 8'h00, 8'h00, 8'h00, 3'd0);
    send_request(ACT_WRITE, 5'h1C, 8'hA5, 8'h00, 8'h00, 3'd0);
    send_request(ACT_READ,  5'h0C, 8'h00, 8'h00, 8'h00, 3'd0);
    send_request(ACT_WRITE, 5'h0C, 8'h5A, 8'h00, 8'h00, 3'd0);
    send_request(ACT_READ,  5'h1C, 8'h00, 8'h00, 8'h00, 3'd0);
    send_request(ACT_WRITE, 5'h1F, 8'h3F, 8'h00, 8'h00, 3'd0);
  endtask

  task automatic test_decode_rows();
    send_request(ACT_WRITE,  5'h1D, 8'hC1, 8'h00, 8'h00, 3'd0);
    send_request(ACT_WRITE,  5'h1E, 8'h7E, 8'h00, 8'h00, 3'd0);
    send_request(ACT_DECODE, 5'h00, 8'h00, 8'hFF, 8'h00, 3'd7);
    send_request(ACT_DECODE, 5'h00, 8'h00, 8'h00, 8'hFF, 3'd7);
    send_request(ACT_DECODE, 5'h00, 8'h00, 8'hAA, 8'h55, 3'd7);
    send_request(ACT_DECODE, 5'h00, 8'h00, 8'hFF, 8'hFF, 3'd7);
    send_request(ACT_DECODE, 5'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    send_request(ACT_DECODE, 5'h00, 8'h00, 8'h0F, 8'hF0, 3'd4);
  endtask

  task automatic test_ignored_action();
    send_request(ACT_IGNORED, 5'h00, 8'h12, 8'hFF, 8'hFF, 3'd7);
    send_request(ACT_READ,    5'h00, 8'h00, 8'h00, 8'h00, 3'd0);
  endtask

  task automatic test_random_traffic();
    gaps_enabled = 1'b1;
    repeat (300) send_random_request();
    gaps_enabled = 1'b0;
    repeat (40) send_random_request();
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_left = 300;
    repeat (16)
      send_request(ACT_DECODE, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   3'($urandom));
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < RAM_DEPTH; i++) palette_shadow[i] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_mirroring();
    test_decode_rows();
    test_ignored_action();
    wait_drained();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/prtd_pkg.sv
rtl/core/prtd_front.sv
rtl/core/prtd_back.sv
rtl/core/palette_ram_tile_row_decoder.sv
tb/tb_top.sv
